>>> design/pqgd_pkg.sv
package pqgd_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int VALUE_W       = 32;
    localparam int IDX_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_DEL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] pri;
        logic [VALUE_W-1:0]       value;
    } entry_t;

    typedef struct packed {
        op_t                      op;
        logic [VALUE_W-1:0]       value;
        logic [PRIORITY_BITS-1:0] pri;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [CNT_W-1:0]         removed;
        logic [CNT_W-1:0]         count;
        logic                     front_valid;
        logic [VALUE_W-1:0]       front_value;
        logic [PRIORITY_BITS-1:0] front_pri;
    } rsp_t;

endpackage

>>> design/pqgd_ram.sv
module pqgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/pqgd_core.sv
module pqgd_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  pqgd_pkg::req_t req,
    output logic          idle,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pqgd_pkg::rsp_t rsp
);
    import pqgd_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  removed_reg, removed_next;
    logic              in_run_reg, in_run_next;
    status_t           status_reg, status_next;
    entry_t            new_reg, new_next;
    entry_t            front_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    entry_t            req_entry;

    pqgd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_entry.pri   = req.pri;
    assign req_entry.value = req.value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
        idx_reg     <= idx_next;
        removed_reg <= removed_next;
        in_run_reg  <= in_run_next;
        status_reg  <= status_next;
        new_reg     <= new_next;
        // slot 0 is mirrored so the front is always at hand
        if (wr_en && wr_addr == '0) begin
            front_reg <= wr_data;
        end
    end

    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        removed_next = removed_reg;
        in_run_next  = in_run_reg;
        status_next  = status_reg;
        new_next     = new_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = new_reg;
        rd_addr      = idx_reg;
        rsp_valid    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    new_next     = req_entry;
                    removed_next = '0;
                    in_run_next  = 1'b1;
                    status_next  = ST_DONE;
                    if (req.op == OP_INSERT) begin
                        if (total_reg == CNT_W'(QUEUE_DEPTH)) begin
                            status_next = ST_OVERFLOW;
                            state_next  = S_DONE;
                        end else if (total_reg == '0) begin
                            wr_en      = 1'b1;
                            wr_data    = req_entry;
                            total_next = CNT_W'(1);
                            state_next = S_DONE;
                        end else begin
                            idx_next   = IDX_W'(total_reg - CNT_W'(1));
                            rd_addr    = IDX_W'(total_reg - CNT_W'(1));
                            state_next = S_INS;
                        end
                    end else begin
                        if (total_reg == '0) begin
                            status_next = ST_UNDERFLOW;
                            state_next  = S_DONE;
                        end else begin
                            idx_next   = '0;
                            rd_addr    = '0;
                            state_next = S_DEL;
                        end
                    end
                end
            end
            S_INS: begin
                // walk from the tail, moving up entries that are less urgent
                wr_en   = 1'b1;
                wr_addr = idx_reg + IDX_W'(1);
                if (rd_data.pri > new_reg.pri) begin
                    wr_data = rd_data;
                    if (idx_reg == '0) begin
                        state_next = S_INS_LAST;
                    end else begin
                        idx_next = idx_reg - IDX_W'(1);
                        rd_addr  = idx_reg - IDX_W'(1);
                    end
                end else begin
                    total_next = total_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_INS_LAST: begin
                wr_en      = 1'b1;
                total_next = total_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DEL: begin
                // count the leading run, then compact the rest down
                if (in_run_reg && rd_data.pri == front_reg.pri) begin
                    removed_next = removed_reg + CNT_W'(1);
                end else begin
                    in_run_next = 1'b0;
                    wr_en       = 1'b1;
                    wr_addr     = IDX_W'(CNT_W'(idx_reg) - removed_reg);
                    wr_data     = rd_data;
                end
                if (CNT_W'(idx_reg) + CNT_W'(1) == total_reg) begin
                    total_next = total_reg - removed_next;
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                    rd_addr  = idx_reg + IDX_W'(1);
                end
            end
            S_DONE: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

    always_comb begin
        rsp.status      = status_reg;
        rsp.removed     = removed_reg;
        rsp.count       = total_reg;
        rsp.front_valid = (total_reg != '0);
        rsp.front_value = rsp.front_valid ? front_reg.value : '0;
        rsp.front_pri   = rsp.front_valid ? front_reg.pri : '0;
    end

endmodule

>>> design/priority_queue_group_delete.sv
// Sorted priority queue of up to 16 (value, priority) entries; smaller
// priority is more urgent, equal priorities leave in arrival order.
// Input words (s_axis): tuser carries the op (insert or delete), tdata the
// value and priority. A delete removes every entry sharing the front
// priority. Each input word yields exactly one result word (m_axis): status
// in tuser, and in tdata the count removed, the count held, and the front.
// An insert's result word waits for the tail-first shift through the store,
// which moves each less urgent entry up one slot (one read and one write per
// cycle); a delete scans every held entry before it answers. Overflow,
// underflow and an insert into an empty queue go straight to the result.
// The sequencer is ready again when its result moves to the output register.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; the next input word is taken while
// it waits. If the receiver stalls, the following result holds in the
// sequencer and no further word is taken until the output register frees.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result. Store contents are not cleared; only written slots are ever read.
module priority_queue_group_delete (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [0:0]  s_axis_tuser,  // op
    input  logic [39:0] s_axis_tdata,  // item_value[31:0], item_priority[39:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,  // status
    // removed_count[4:0], entry_count[9:5], front_valid[10],
    // front_value[42:11], front_priority[50:43], zero fill
    output logic [55:0] m_axis_tdata
);
    import pqgd_pkg::*;

    req_t        req;
    rsp_t        rsp;
    logic        core_idle;
    logic        rsp_valid;
    logic        rsp_ready;
    logic        start;
    logic        m_valid_reg;
    logic [1:0]  m_user_reg;
    logic [55:0] m_data_reg;

    assign req.op    = op_t'(s_axis_tuser[0]);
    assign req.value = s_axis_tdata[31:0];
    assign req.pri   = PRIORITY_BITS'(s_axis_tdata[39:32]);

    assign s_axis_tready = core_idle;
    assign start         = s_axis_tvalid && core_idle;
    assign rsp_ready     = !m_valid_reg || m_axis_tready;

    pqgd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req),
        .idle      (core_idle),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rsp_ready) begin
            m_valid_reg <= rsp_valid;
        end
        if (rsp_ready && rsp_valid) begin
            m_user_reg <= rsp.status;
            m_data_reg <= {5'd0,
                           8'(rsp.front_pri),
                           rsp.front_value,
                           rsp.front_valid,
                           5'(rsp.count),
                           5'(rsp.removed)};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tdata  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == ST_OVERFLOW |->
            m_axis_tdata[9:5] == 5'(QUEUE_DEPTH))
        else $error("overflow reported on a queue that is not full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == ST_UNDERFLOW |->
            m_axis_tdata[9:5] == 5'd0 && !m_axis_tdata[10])
        else $error("underflow reported on a queue that is not empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[10] == (m_axis_tdata[9:5] != 5'd0))
        else $error("front valid disagrees with entry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[4:0] != 5'd0 |-> m_axis_tuser == ST_DONE)
        else $error("entries removed on a failed operation");

    assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid && !rsp_ready |=> !s_axis_tready)
        else $error("input taken while a result is held back");

endmodule
